@@ rtl/ues_pkg.sv @@
// Shared types, code point constants and classification helpers for the emoji stripper.
package ues_pkg;

  typedef logic [20:0] cp_t;

  localparam cp_t CP_ZWJ    = 21'h0200D;
  localparam cp_t CP_KEYCAP = 21'h020E3;
  localparam cp_t CP_VS16   = 21'h0FE0F;
  localparam cp_t CP_COPY   = 21'h000A9;
  localparam cp_t CP_REG    = 21'h000AE;
  localparam cp_t CP_TM     = 21'h02122;

  // One decoded code point, or an end-of-item marker when mark is set.
  typedef struct packed {
    logic            mark;
    logic            text_end;
    logic            emoji;
    logic            joiner;
    logic            fe0f;
    logic            symbol;
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
  } tok_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_last;
    logic       text_done;
    logic       any_removed;
  } res_t;

  typedef enum logic {
    F_IDLE,
    F_DRAIN
  } front_state_t;

  typedef enum logic [1:0] {
    B_POP,
    B_HELD,
    B_CP,
    B_ENDRES
  } back_state_t;

  function automatic logic is_emoji(cp_t cp);
    return cp inside {[21'h1F000:21'h1FAFF], [21'h02600:21'h027BF], [21'h02B00:21'h02BFF],
                      [21'h0231A:21'h0231B], [21'h023E9:21'h023EC], 21'h023F0, 21'h023F3,
                      [21'h023F8:21'h023FA], 21'h025AA, 21'h025AB, 21'h025B6, 21'h025C0,
                      [21'h025FB:21'h025FE], CP_VS16};
  endfunction

  function automatic logic [2:0] seq_len(logic [7:0] b0);
    logic [2:0] len;
    if (b0[7] == 1'b0) begin
      len = 3'd1;
    end else if (b0[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b0[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b0[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

endpackage

@@ rtl/ues_channels.sv @@
// Valid/ready channel interfaces for the text input and the result output.
interface ues_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, in_byte, text_end, input ready);
  modport sink (input valid, in_byte, text_end, output ready);
endinterface

interface ues_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       text_done;
  logic       any_removed;

  modport source (output valid, out_byte, byte_present, run_last, text_done, any_removed,
                  input ready);
  modport sink (input valid, out_byte, byte_present, run_last, text_done, any_removed,
                output ready);
endinterface

@@ rtl/ues_queue.sv @@
// Small token queue between the decoder front and the filter back.
module ues_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ues_pkg::tok_t wr_tok,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ues_pkg::tok_t rd_tok
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ues_pkg::tok_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    full    = (cnt_r == CW'(DEPTH));
    valid   = (cnt_r != '0);
    rd_tok  = mem_r[rp_r];
    do_push = push && !full;
    do_pop  = pop && valid;
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_tok;
    end
  end

endmodule

@@ rtl/ues_front.sv @@
// Front end: accepts text bytes, decodes UTF-8 code points and classifies them.
module ues_front (
  input  logic          clk,
  input  logic          rst_n,
  ues_in_if.sink        in_ch,
  output logic          q_push,
  output ues_pkg::tok_t q_tok,
  input  logic          q_full
);

  logic [3:0][7:0]       seq_r, seq_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic                  end_r, end_nxt;
  ues_pkg::front_state_t st_r, st_nxt;

  logic [2:0]    need, lim, take_n, src;
  logic          bad, full_seq, stop;
  ues_pkg::cp_t  cp;

  always_comb begin
    need = ues_pkg::seq_len(seq_r[0]);
    lim  = (cnt_r < need) ? cnt_r : need;
    bad  = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (3'(k) < lim && seq_r[k][7:6] != 2'b10) begin
        bad = 1'b1;
      end
    end
    full_seq = !bad && (cnt_r >= need);
    stop     = (cnt_r == 3'd0) || (!bad && (cnt_r < need) && !end_r);
    take_n   = full_seq ? need : 3'd1;

    case (need)
      3'd2:    cp = {10'd0, seq_r[0][4:0], seq_r[1][5:0]};
      3'd3:    cp = {5'd0, seq_r[0][3:0], seq_r[1][5:0], seq_r[2][5:0]};
      3'd4:    cp = {seq_r[0][2:0], seq_r[1][5:0], seq_r[2][5:0], seq_r[3][5:0]};
      default: cp = {13'd0, seq_r[0]};
    endcase
    if (!full_seq) begin
      cp = {13'd0, seq_r[0]};
    end

    q_tok.mark     = stop;
    q_tok.text_end = end_r;
    q_tok.emoji    = ues_pkg::is_emoji(cp);
    q_tok.joiner   = (cp == ues_pkg::CP_ZWJ) || (cp == ues_pkg::CP_KEYCAP);
    q_tok.fe0f     = (cp == ues_pkg::CP_VS16);
    q_tok.symbol   = (cp == ues_pkg::CP_COPY) || (cp == ues_pkg::CP_REG) ||
                     (cp == ues_pkg::CP_TM);
    q_tok.n        = take_n;
    q_tok.bytes    = seq_r;

    q_push      = (st_r == ues_pkg::F_DRAIN) && !q_full;
    in_ch.ready = (st_r == ues_pkg::F_IDLE) || ((st_r == ues_pkg::F_DRAIN) && stop && !q_full);

    seq_nxt = seq_r;
    cnt_nxt = cnt_r;
    end_nxt = end_r;
    st_nxt  = st_r;
    src     = '0;

    if (st_r == ues_pkg::F_DRAIN && !q_full) begin
      if (stop) begin
        st_nxt = ues_pkg::F_IDLE;
        if (end_r) begin
          cnt_nxt = '0;
        end
      end else begin
        // advance past the bytes just decoded
        for (int k = 0; k < 4; k++) begin
          src = 3'(k) + take_n;
          if (src < 3'd4) begin
            seq_nxt[k] = seq_r[src[1:0]];
          end
        end
        cnt_nxt = cnt_r - take_n;
      end
    end

    if (in_ch.valid && in_ch.ready) begin
      seq_nxt[cnt_nxt[1:0]] = in_ch.in_byte;
      cnt_nxt               = cnt_nxt + 3'd1;
      end_nxt               = in_ch.text_end;
      st_nxt                = ues_pkg::F_DRAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ues_pkg::F_IDLE;
      cnt_r <= '0;
      end_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      end_r <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
  end

endmodule

@@ rtl/ues_back.sv @@
// Back end: filters code points, holds symbols for lookahead and emits result items.
module ues_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ues_pkg::tok_t q_tok,
  output logic          q_pop,
  ues_out_if.source     out_ch
);

  ues_pkg::back_state_t st_r, st_nxt;
  ues_pkg::tok_t        cur_r, cur_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic [3:0][7:0]      held_r, held_nxt;
  logic [2:0]           held_n_r, held_n_nxt;
  logic                 prev_r, prev_nxt;
  logic                 removed_r, removed_nxt;
  logic                 pend_v_r, pend_v_nxt;
  ues_pkg::res_t        pend_r, pend_nxt;
  logic                 out_v_r, out_v_nxt;
  ues_pkg::res_t        out_r, out_nxt;

  ues_pkg::tok_t dtok;
  ues_pkg::res_t res_new;
  logic          dprev, drop, do_decide, push, mark_last, out_free, can_push, move;

  always_comb begin
    out_free = !out_v_r || out_ch.ready;
    can_push = !pend_v_r || out_free;

    st_nxt      = st_r;
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    held_nxt    = held_r;
    held_n_nxt  = held_n_r;
    prev_nxt    = prev_r;
    removed_nxt = removed_r;
    q_pop       = 1'b0;
    push        = 1'b0;
    mark_last   = 1'b0;
    do_decide   = 1'b0;
    res_new     = '0;

    dtok  = (st_r == ues_pkg::B_POP) ? q_tok : cur_r;
    dprev = (st_r == ues_pkg::B_POP) ? prev_r : 1'b0;
    drop  = dtok.emoji || (dtok.joiner && dprev);

    case (st_r)
      ues_pkg::B_POP: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_tok.mark) begin
            if (!q_tok.text_end) begin
              mark_last = 1'b1;
            end else begin
              cur_nxt = q_tok;
              idx_nxt = '0;
              st_nxt  = (held_n_r != 3'd0) ? ues_pkg::B_HELD : ues_pkg::B_ENDRES;
            end
          end else if (held_n_r != 3'd0) begin
            if (q_tok.fe0f) begin
              held_n_nxt  = '0;
              removed_nxt = 1'b1;
              prev_nxt    = 1'b1;
            end else begin
              cur_nxt = q_tok;
              idx_nxt = '0;
              st_nxt  = ues_pkg::B_HELD;
            end
          end else begin
            do_decide = 1'b1;
          end
        end
      end
      ues_pkg::B_HELD: begin
        if (can_push) begin
          push                 = 1'b1;
          res_new.out_byte     = held_r[idx_r];
          res_new.byte_present = 1'b1;
          if ({1'b0, idx_r} == held_n_r - 3'd1) begin
            held_n_nxt = '0;
            prev_nxt   = 1'b0;
            idx_nxt    = '0;
            if (cur_r.mark) begin
              st_nxt = ues_pkg::B_ENDRES;
            end else begin
              st_nxt    = ues_pkg::B_POP;
              do_decide = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ues_pkg::B_CP: begin
        if (can_push) begin
          push                 = 1'b1;
          res_new.out_byte     = cur_r.bytes[idx_r];
          res_new.byte_present = 1'b1;
          if ({1'b0, idx_r} == cur_r.n - 3'd1) begin
            prev_nxt = 1'b0;
            st_nxt   = ues_pkg::B_POP;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ues_pkg::B_ENDRES: begin
        if (can_push) begin
          push                = 1'b1;
          res_new.text_done   = 1'b1;
          res_new.any_removed = removed_r;
          res_new.run_last    = 1'b1;
          held_n_nxt          = '0;
          prev_nxt            = 1'b0;
          removed_nxt         = 1'b0;
          st_nxt              = ues_pkg::B_POP;
        end
      end
      default: st_nxt = ues_pkg::B_POP;
    endcase

    if (do_decide) begin
      if (drop) begin
        removed_nxt = 1'b1;
        prev_nxt    = 1'b1;
        st_nxt      = ues_pkg::B_POP;
      end else if (dtok.symbol) begin
        held_nxt   = dtok.bytes;
        held_n_nxt = dtok.n;
        st_nxt     = ues_pkg::B_POP;
      end else begin
        cur_nxt = dtok;
        idx_nxt = '0;
        st_nxt  = ues_pkg::B_CP;
      end
    end

    // pending result leaves once a later one arrives or its item is known complete
    move      = pend_v_r && out_free && (push || pend_r.run_last);
    out_v_nxt = out_v_r && !out_ch.ready;
    out_nxt   = out_r;
    if (move) begin
      out_v_nxt = 1'b1;
      out_nxt   = pend_r;
    end
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (move) begin
      pend_v_nxt = 1'b0;
    end
    if (mark_last && pend_v_r) begin
      pend_nxt.run_last = 1'b1;
    end
    if (push) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = res_new;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_byte     = out_r.out_byte;
  assign out_ch.byte_present = out_r.byte_present;
  assign out_ch.run_last     = out_r.run_last;
  assign out_ch.text_done    = out_r.text_done;
  assign out_ch.any_removed  = out_r.any_removed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ues_pkg::B_POP;
      idx_r     <= '0;
      held_n_r  <= '0;
      prev_r    <= 1'b0;
      removed_r <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      idx_r     <= idx_nxt;
      held_n_r  <= held_n_nxt;
      prev_r    <= prev_nxt;
      removed_r <= removed_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    held_r <= held_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

@@ rtl/utf8_emoji_stripper_unit.sv @@
// Top level of the UTF-8 emoji stripper: front decoder, token queue and filter back end.
// Text enters one byte per item and leaves as the bytes of the kept code points, with a
// final end-only item per text. The front takes a byte and then pushes a token per
// decoded code point plus one end-of-item marker token, whose push overlaps the next
// accept; the bytes of a broken sequence that follow its lead byte are decoded again as
// code points of their own. The back pops each token, code point or end-of-item marker,
// and writes each result in a step of its own, so for plain ASCII text the back is the
// slower side and sets the sustained rate; a dropped or held code point takes only its
// pop. A queue of QUEUE_DEPTH tokens between the two lets either side stall without
// stopping the other until the queue fills or runs empty.
module utf8_emoji_stripper_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  ues_in_if.sink    in_ch,
  ues_out_if.source out_ch
);

  logic          q_push, q_full, q_pop, q_valid;
  ues_pkg::tok_t q_wr_tok, q_rd_tok;

  ues_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_tok  (q_wr_tok),
    .q_full (q_full)
  );

  ues_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_tok (q_wr_tok),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_tok (q_rd_tok)
  );

  ues_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_tok   (q_rd_tok),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("token pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("token popped from an empty queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.text_done) |-> (out_ch.run_last && !out_ch.byte_present))
    else $error("end-of-text item not marked last or carries a byte");

endmodule

@@ dv/utf8_emoji_stripper_unit_test.sv @@
// Testbench for the UTF-8 emoji stripper: random and directed texts against a stripping model.
module utf8_emoji_stripper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ues_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int RANDOM_ITEMS = 380;
  localparam int PHASE_ITEMS  = 50;
  localparam int LONG_HOLD    = 200;

  class strip_scoreboard;
    res_t       expected_q[$];
    int         mismatches;
    logic [7:0] seq_q[$];
    logic [7:0] held_q[$];
    logic       prev_dropped;
    logic       removed_seen;
    res_t       last_res;
    bit         have_last;

    function new();
      mismatches = 0;
      have_last = 1'b0;
      clear_text();
    endfunction

    function void clear_text();
      seq_q.delete();
      held_q.delete();
      prev_dropped = 1'b0;
      removed_seen = 1'b0;
    endfunction

    function void push_res(logic [7:0] b, logic present, logic done, logic any);
      if (have_last) begin
        expected_q.insert(expected_q.size(), last_res);
      end
      last_res = '{out_byte: b, byte_present: present, run_last: 1'b0,
                   text_done: done, any_removed: any};
      have_last = 1'b1;
    endfunction

    function bit is_dropped_cp(int unsigned cp);
      if (cp >= 32'h1F000 && cp <= 32'h1FAFF) return 1'b1;
      if (cp >= 32'h02600 && cp <= 32'h027BF) return 1'b1;
      if (cp >= 32'h02B00 && cp <= 32'h02BFF) return 1'b1;
      if (cp == 32'h0231A || cp == 32'h0231B) return 1'b1;
      if (cp >= 32'h023E9 && cp <= 32'h023EC) return 1'b1;
      if (cp == 32'h023F0 || cp == 32'h023F3) return 1'b1;
      if (cp >= 32'h023F8 && cp <= 32'h023FA) return 1'b1;
      if (cp == 32'h025AA || cp == 32'h025AB || cp == 32'h025B6 || cp == 32'h025C0) return 1'b1;
      if (cp >= 32'h025FB && cp <= 32'h025FE) return 1'b1;
      return cp == CP_VS16;
    endfunction

    function int unsigned lead_need(logic [7:0] b0);
      casez (b0)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 1;
      endcase
    endfunction

    function void pass_held();
      foreach (held_q[k]) begin
        push_res(held_q[k], 1'b1, 1'b0, 1'b0);
      end
      held_q.delete();
    endfunction

    function void take_cp(int unsigned cp, byte_q_t cp_bytes);
      if (held_q.size() != 0) begin
        if (cp == CP_VS16) begin
          held_q.delete();
          removed_seen = 1'b1;
          prev_dropped = 1'b1;
          return;
        end
        pass_held();
        prev_dropped = 1'b0;
      end
      if (is_dropped_cp(cp) || ((cp == CP_ZWJ || cp == CP_KEYCAP) && prev_dropped)) begin
        removed_seen = 1'b1;
        prev_dropped = 1'b1;
        return;
      end
      if (cp == CP_COPY || cp == CP_REG || cp == CP_TM) begin
        held_q = cp_bytes;
        return;
      end
      foreach (cp_bytes[k]) begin
        push_res(cp_bytes[k], 1'b1, 1'b0, 1'b0);
      end
      prev_dropped = 1'b0;
    endfunction

    function void decode(bit at_end);
      logic [7:0]  b0;
      int unsigned need;
      int unsigned lim;
      int unsigned cp;
      bit          bad;
      byte_q_t     cp_bytes;
      while (seq_q.size() > 0) begin
        b0 = seq_q[0];
        need = lead_need(b0);
        bad = 1'b0;
        if (need > 1) begin
          lim = (seq_q.size() < need) ? seq_q.size() : need;
          for (int k = 1; k < lim; k++) begin
            if (seq_q[k][7:6] != 2'b10) bad = 1'b1;
          end
          if (!bad && seq_q.size() < need && !at_end) break;
          if (!bad && seq_q.size() >= need) begin
            cp = b0 & (32'h7F >> need);
            cp_bytes.delete();
            cp_bytes.insert(cp_bytes.size(), b0);
            for (int k = 1; k < need; k++) begin
              cp = (cp << 6) | seq_q[k][5:0];
              cp_bytes.insert(cp_bytes.size(), seq_q[k]);
            end
            repeat (need) void'(seq_q.pop_front());
            take_cp(cp, cp_bytes);
            continue;
          end
        end
        void'(seq_q.pop_front());
        cp_bytes.delete();
        cp_bytes.insert(cp_bytes.size(), b0);
        take_cp(b0, cp_bytes);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      seq_q.insert(seq_q.size(), b);
      decode(last);
      if (last) begin
        pass_held();
        push_res(8'h00, 1'b0, 1'b1, removed_seen);
        clear_text();
      end
      if (have_last) begin
        last_res.run_last = 1'b1;
        expected_q.insert(expected_q.size(), last_res);
        have_last = 1'b0;
      end
    endfunction

    task report(string msg);
      if (mismatches < 40) begin
        $display("%0t mismatch: %s", $time, msg);
      end
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result byte=%h present=%b done=%b",
                         got.out_byte, got.byte_present, got.text_done));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.byte_present !== want.byte_present)
        report($sformatf("byte_present %b, want %b", got.byte_present, want.byte_present));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
      if (got.text_done !== want.text_done)
        report($sformatf("text_done %b, want %b", got.text_done, want.text_done));
      if (got.any_removed !== want.any_removed)
        report($sformatf("any_removed %b, want %b", got.any_removed, want.any_removed));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ues_in_if  in_ch();
  ues_out_if out_ch();

  utf8_emoji_stripper_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  strip_scoreboard strip = new();

  int unsigned special_cps[$] = '{
    32'h1F000, 32'h1FAFF, 32'h1EFFF, 32'h1FB00, 32'h1F600, 32'h02600, 32'h027BF, 32'h025FF,
    32'h027C0, 32'h02B00, 32'h02BFF, 32'h02AFF, 32'h02C00, 32'h0231A, 32'h0231B, 32'h02319,
    32'h0231C, 32'h023E9, 32'h023EC, 32'h023E8, 32'h023ED, 32'h023F0, 32'h023F3, 32'h023F1,
    32'h023F8, 32'h023FA, 32'h023FB, 32'h025AA, 32'h025AB, 32'h025B6, 32'h025C0, 32'h025FB,
    32'h025FE, 32'h025FA, 32'h0200D, 32'h020E3, 32'h0FE0F, 32'h0FE0E, 32'h000A9, 32'h000AE,
    32'h02122
  };

  int gap_max;
  int stall_max;
  int burst_left;
  int items_sent;
  bit long_hold_req;
  res_t seen_res;

  always #10 clk = ~clk;

  function automatic void add_cp(ref byte_q_t q, input int unsigned cp);
    if (cp < 32'h80) begin
      q.insert(q.size(), cp[7:0]);
    end else if (cp < 32'h800) begin
      q.insert(q.size(), {3'b110, cp[10:6]});
      q.insert(q.size(), {2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      q.insert(q.size(), {4'b1110, cp[15:12]});
      q.insert(q.size(), {2'b10, cp[11:6]});
      q.insert(q.size(), {2'b10, cp[5:0]});
    end else begin
      q.insert(q.size(), {5'b11110, cp[20:18]});
      q.insert(q.size(), {2'b10, cp[17:12]});
      q.insert(q.size(), {2'b10, cp[11:6]});
      q.insert(q.size(), {2'b10, cp[5:0]});
    end
  endfunction

  function automatic int unsigned symbol_cp();
    case ($urandom_range(0, 2))
      0:       return CP_COPY;
      1:       return CP_REG;
      default: return CP_TM;
    endcase
  endfunction

  function automatic void add_token(ref byte_q_t q);
    int unsigned pick;
    int unsigned cut;
    byte_q_t     part;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      add_cp(q, $urandom_range(0, 32'h7F));
    end else if (pick < 42) begin
      add_cp(q, special_cps[$urandom_range(0, special_cps.size() - 1)]);
    end else if (pick < 50) begin
      add_cp(q, $urandom_range(32'h80, 32'h7FF));
    end else if (pick < 58) begin
      add_cp(q, $urandom_range(32'h800, 32'hFFFF));
    end else if (pick < 66) begin
      add_cp(q, $urandom_range(0, 1) ? $urandom_range(32'h1F000, 32'h1FAFF)
                                     : $urandom_range(32'h10000, 32'h1FFFFF));
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: begin
          add_cp(q, $urandom_range(32'h1F300, 32'h1F6FF));
          add_cp(q, CP_ZWJ);
          add_cp(q, $urandom_range(32'h2600, 32'h27BF));
        end
        1: begin
          add_cp(q, symbol_cp());
          add_cp(q, CP_VS16);
        end
        2: begin
          add_cp(q, $urandom_range(32'h30, 32'h39));
          add_cp(q, CP_VS16);
          add_cp(q, CP_KEYCAP);
        end
        default: begin
          add_cp(q, symbol_cp());
          add_cp(q, $urandom_range(0, 1) ? int'(CP_ZWJ) : $urandom_range(0, 32'h7F));
        end
      endcase
    end else if (pick < 90) begin
      q.insert(q.size(), 8'($urandom_range(32'h80, 32'hFF)));
    end else begin
      add_cp(part, $urandom_range(32'h80, 32'h1FFFFF));
      cut = $urandom_range(1, part.size() - 1);
      for (int k = 0; k < cut; k++) begin
        q.insert(q.size(), part[k]);
      end
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.text_end <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    strip.note_byte(b, last);
    items_sent++;
  endtask

  task automatic send_text(byte_q_t t);
    foreach (t[k]) begin
      send_byte(t[k], k == t.size() - 1);
    end
  endtask

  task automatic send_random_text();
    byte_q_t t;
    int      tokens;
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
    repeat (tokens) add_token(t);
    send_text(t);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (strip.expected_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_res = '{out_byte: out_ch.out_byte, byte_present: out_ch.byte_present,
                   run_last: out_ch.run_last, text_done: out_ch.text_done,
                   any_removed: out_ch.any_removed};
      strip.check_result(seen_res);
    end
  end

  initial begin
    int run_left;
    int hold_left;
    bit rdy;
    run_left = 0;
    hold_left = 0;
    rdy = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_max == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rdy = !rdy;
          run_left = rdy ? $urandom_range(1, 8) : $urandom_range(1, stall_max);
        end
        run_left--;
        out_ch.ready <= rdy;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    byte_q_t t;
    int      phase_start;
    int      random_start;
    gap_max = 0;
    stall_max = 0;
    burst_left = 0;
    items_sent = 0;
    long_hold_req = 1'b0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.text_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    t = '{8'h7F, 8'h80, 8'hFF};
    send_text(t);
    t = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h80, 8'h8D, 8'h41};
    send_text(t);
    t = '{8'hC2, 8'hA9, 8'hEF, 8'hB8, 8'h8F, 8'h31, 8'hE2, 8'h83, 8'hA3};
    send_text(t);
    t = '{8'hAE, 8'h00, 8'hA9};
    send_text(t);
    t = '{8'hE2, 8'h41, 8'hF0, 8'h9F};
    send_text(t);
    wait_drained();

    random_start = items_sent;
    for (int phase = 0; items_sent - random_start < RANDOM_ITEMS; phase++) begin
      case (phase % 5)
        0: begin gap_max = 0;  stall_max = 0;  end
        1: begin gap_max = 5;  stall_max = 4;  end
        2: begin gap_max = 0;  stall_max = 12; end
        3: begin gap_max = 12; stall_max = 0;  end
        default: begin
          gap_max = 0;
          stall_max = 0;
          long_hold_req = 1'b1;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS &&
             items_sent - random_start < RANDOM_ITEMS) begin
        send_random_text();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (strip.mismatches == 0 && strip.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ utf8_emoji_stripper_unit.f @@
rtl/ues_pkg.sv
rtl/ues_channels.sv
rtl/ues_queue.sv
rtl/ues_front.sv
rtl/ues_back.sv
rtl/utf8_emoji_stripper_unit.sv
dv/utf8_emoji_stripper_unit_test.sv
